// File: hdl/length_prefixed_request_deframer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the request deframer
// Shared concurrent assertion forms, clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_MACROS_SVH

// property checked at every edge outside reset
`define LPRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked at every edge outside reset
`define LPRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/lprd_pkg.sv
// ---------------------------------------------------------------------------
// Request deframer package
// Widths, limits, result codes and transfer types shared by the block.
// ---------------------------------------------------------------------------
package lprd_pkg;

  localparam int unsigned MSG_W   = 13;
  localparam int unsigned ARGS_W  = 11;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned HDR_W   = 32;

  localparam logic [MSG_W-1:0]  MAX_MESSAGE = 13'd4096;
  localparam logic [ARGS_W-1:0] MAX_ARGS    = 11'd1024;
  localparam logic [HDR_W-1:0]  MIN_LENGTH  = 32'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LONG    = 3'd4;

  // configuration register indexes
  localparam logic CFG_MAX_MESSAGE = 1'b0;
  localparam logic CFG_MAX_ARGS    = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       connection_start;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        payload_byte;
    logic [IDX_W-1:0]  arg_index;
    logic              arg_end;
    logic              last;
  } out_item_t;

  // results produced by one transfer, first then second
  typedef struct packed {
    logic [1:0] num;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

endpackage

// File: hdl/lprd_parser.sv
// ---------------------------------------------------------------------------
// Request parser
// Header, count, size and payload tracking; yields up to two results a byte.
// ---------------------------------------------------------------------------
`include "length_prefixed_request_deframer_macros.svh"

module lprd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  lprd_pkg::in_item_t            item_i,
  input  logic [lprd_pkg::MSG_W-1:0]    lim_msg_i,
  input  logic [lprd_pkg::ARGS_W-1:0]   lim_args_i,
  output lprd_pkg::push_t               push_o
);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_COUNT,
    PH_SIZE,
    PH_PAYLOAD
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [1:0]                    hcnt_q, hcnt_d;
  logic [23:0]                   hdr_q, hdr_d;
  logic [lprd_pkg::MSG_W-1:0]    mbl_q, mbl_d;
  logic [lprd_pkg::ARGS_W-1:0]   al_q, al_d;
  logic [lprd_pkg::MSG_W-1:0]    abl_q, abl_d;
  logic [lprd_pkg::IDX_W-1:0]    cur_q, cur_d;
  logic                          dead_q, dead_d;

  logic [lprd_pkg::MSG_W-1:0]    mbl_dec, abl_dec;
  logic [lprd_pkg::ARGS_W-1:0]   al_dec;
  logic [lprd_pkg::HDR_W-1:0]    hval;
  logic                          hdr_done;
  logic                          do_fail, do_done, do_finish, emit_main;
  logic [lprd_pkg::KIND_W-1:0]   fail_kind;
  lprd_pkg::out_item_t           main_res, stat_res;

  assign mbl_dec  = (mbl_q != '0) ? mbl_q - 1'b1 : mbl_q;
  assign abl_dec  = (abl_q != '0) ? abl_q - 1'b1 : abl_q;
  assign al_dec   = (al_q != '0) ? al_q - 1'b1 : al_q;
  assign hval     = {item_i.stream_byte, hdr_q};
  assign hdr_done = (hcnt_q == 2'd3);

  always_comb begin
    phase_d   = phase_q;
    hcnt_d    = hcnt_q;
    hdr_d     = hdr_q;
    mbl_d     = mbl_q;
    al_d      = al_q;
    abl_d     = abl_q;
    cur_d     = cur_q;
    dead_d    = dead_q;
    do_fail   = 1'b0;
    do_done   = 1'b0;
    do_finish = 1'b0;
    emit_main = 1'b0;
    fail_kind = lprd_pkg::KIND_BAD;
    main_res  = '0;
    stat_res  = '0;

    if (accept_i && item_i.connection_start) begin
      phase_d = PH_LEN;
      hcnt_d  = '0;
      hdr_d   = '0;
      mbl_d   = '0;
      al_d    = '0;
      abl_d   = '0;
      cur_d   = '0;
      dead_d  = 1'b0;
    end else if (accept_i && !dead_q) begin
      // header bytes collect little-endian, the fourth is combined live
      if (phase_q != PH_PAYLOAD) begin
        hcnt_d = hcnt_q + 2'd1;
        case (hcnt_q)
          2'd0:    hdr_d[7:0]   = item_i.stream_byte;
          2'd1:    hdr_d[15:8]  = item_i.stream_byte;
          2'd2:    hdr_d[23:16] = item_i.stream_byte;
          default: hdr_d        = hdr_q;
        endcase
      end
      case (phase_q)
        PH_LEN: begin
          if (hdr_done) begin
            if (hval > {19'd0, lim_msg_i}) begin
              do_fail   = 1'b1;
              fail_kind = lprd_pkg::KIND_LONG;
            end else if (hval < lprd_pkg::MIN_LENGTH) begin
              do_fail = 1'b1;
            end else begin
              mbl_d   = hval[lprd_pkg::MSG_W-1:0];
              phase_d = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          mbl_d = mbl_dec;
          if (hdr_done) begin
            if (hval > {21'd0, lim_args_i}) begin
              do_fail = 1'b1;
            end else if (hval == '0) begin
              if (mbl_dec == '0) do_done = 1'b1;
              else do_fail = 1'b1;
            end else if (mbl_dec == '0) begin
              do_fail = 1'b1;
            end else begin
              al_d    = hval[lprd_pkg::ARGS_W-1:0];
              cur_d   = '0;
              phase_d = PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          mbl_d = mbl_dec;
          if (!hdr_done) begin
            // body ran out inside a size header
            if (mbl_dec == '0) do_fail = 1'b1;
          end else if (hval > {19'd0, mbl_dec}) begin
            do_fail = 1'b1;
          end else if (hval == '0) begin
            emit_main          = 1'b1;
            main_res.kind      = lprd_pkg::KIND_EMPTY;
            main_res.arg_index = cur_q;
            do_finish          = 1'b1;
          end else begin
            abl_d   = hval[lprd_pkg::MSG_W-1:0];
            phase_d = PH_PAYLOAD;
          end
        end
        default: begin
          mbl_d                 = mbl_dec;
          abl_d                 = abl_dec;
          emit_main             = 1'b1;
          main_res.kind         = lprd_pkg::KIND_PAYLOAD;
          main_res.payload_byte = item_i.stream_byte;
          main_res.arg_index    = cur_q;
          main_res.arg_end      = (abl_dec == '0);
          do_finish             = (abl_dec == '0);
        end
      endcase

      if (do_finish) begin
        al_d  = al_dec;
        cur_d = cur_q + 1'b1;
        if (al_dec == '0) begin
          if (mbl_dec == '0) do_done = 1'b1;
          else do_fail = 1'b1;
        end else if (mbl_dec == '0) begin
          do_fail = 1'b1;
        end else begin
          phase_d = PH_SIZE;
        end
      end

      if (do_fail || do_done) begin
        phase_d       = PH_LEN;
        hcnt_d        = '0;
        hdr_d         = '0;
        mbl_d         = '0;
        al_d          = '0;
        abl_d         = '0;
        cur_d         = '0;
        dead_d        = do_fail;
        stat_res.kind = do_fail ? fail_kind : lprd_pkg::KIND_DONE;
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (emit_main && (do_fail || do_done)) begin
      push_o.num     = 2'd2;
      push_o.r0      = main_res;
      push_o.r1      = stat_res;
      push_o.r1.last = 1'b1;
    end else if (emit_main) begin
      push_o.num     = 2'd1;
      push_o.r0      = main_res;
      push_o.r0.last = 1'b1;
    end else if (do_fail || do_done) begin
      push_o.num     = 2'd1;
      push_o.r0      = stat_res;
      push_o.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      hcnt_q  <= '0;
      hdr_q   <= '0;
      mbl_q   <= '0;
      al_q    <= '0;
      abl_q   <= '0;
      cur_q   <= '0;
      dead_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      hdr_q   <= hdr_d;
      mbl_q   <= mbl_d;
      al_q    <= al_d;
      abl_q   <= abl_d;
      cur_q   <= cur_d;
      dead_q  <= dead_d;
    end
  end

  // a second result is always a status closing the request
  `LPRD_ASSERT_IMP(a_pair_ends_status, clk_i, rst_ni, push_o.num == 2'd2, (push_o.r1.kind != lprd_pkg::KIND_PAYLOAD) && (push_o.r1.kind != lprd_pkg::KIND_EMPTY) && !push_o.r0.last, "second result is not a closing status")
  // a dead connection stays silent until a new connection starts
  `LPRD_ASSERT_IMP(a_dead_silent, clk_i, rst_ni, dead_q && !(accept_i && item_i.connection_start), push_o.num == 2'd0 && dead_d, "dead connection produced a result")

endmodule

// File: hdl/lprd_result_fifo.sv
// ---------------------------------------------------------------------------
// Result queue
// Four-entry queue, up to two results in per cycle, one out unless stalled.
// ---------------------------------------------------------------------------
`include "length_prefixed_request_deframer_macros.svh"

module lprd_result_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lprd_pkg::push_t      push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lprd_pkg::out_item_t  out_item_o
);

  lprd_pkg::out_item_t             mem_q [lprd_pkg::FIFO_DEPTH];
  logic [lprd_pkg::FIFO_AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [lprd_pkg::FIFO_AW:0]      cnt_q, cnt_d;
  logic                            pop;
  logic [lprd_pkg::FIFO_AW-1:0]    wp_next;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rp_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for the largest burst one transfer can cause
  assign room_o      = (cnt_q <= (lprd_pkg::FIFO_AW+1)'(lprd_pkg::FIFO_DEPTH - 2));
  assign wp_next     = wp_q + 1'b1;

  always_comb begin
    wp_d  = wp_q + push_i.num[lprd_pkg::FIFO_AW-1:0];
    rp_d  = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + {1'b0, push_i.num} - {{lprd_pkg::FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wp_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  `LPRD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= (lprd_pkg::FIFO_AW+1)'(lprd_pkg::FIFO_DEPTH), "queue count above depth")
  `LPRD_ASSERT(a_ptr_match, clk_i, rst_ni, (wp_q - rp_q) == cnt_q[lprd_pkg::FIFO_AW-1:0], "queue pointers disagree with count")
  `LPRD_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i.num != 2'd0, (cnt_q + {1'b0, push_i.num}) <= (lprd_pkg::FIFO_AW+1)'(lprd_pkg::FIFO_DEPTH), "push into full queue")

endmodule

// File: hdl/length_prefixed_request_deframer.sv
// ---------------------------------------------------------------------------
// Length-prefixed request deframer
// Splits a byte stream of length-framed requests into tagged argument bytes.
//
// Input channel: in_valid_i / in_stall_o / in_item_i, one stream byte or a
// connection-start mark per transfer. Output channel: out_valid_o /
// out_stall_i / out_item_o, one result per transfer (payload byte, empty
// argument marker or request status), the last result of a byte flagged.
// A byte is parsed in the cycle it is taken; its results are registered in a
// four-entry queue whose head drives the output. A byte may be taken every
// cycle; a byte yields zero to two results and the output moves one per cycle
// unless stalled, so bursts of two-result bytes are paced by the queue.
// in_stall_o is high while the queue has fewer than two free entries.
// Reset clears the parser and queue and loads limits 4096 and 1024.
// While the receiver stalls, the queue fills and then stalls the input.
// Limit registers are written through cfg_we_i / cfg_index_i / cfg_data_i.
// ---------------------------------------------------------------------------
module length_prefixed_request_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lprd_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lprd_pkg::out_item_t         out_item_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [lprd_pkg::CFG_W-1:0]  cfg_data_i
);

  logic [lprd_pkg::MSG_W-1:0]   max_msg_q;
  logic [lprd_pkg::ARGS_W-1:0]  max_args_q;
  logic [lprd_pkg::MSG_W-1:0]   lim_msg;
  logic [lprd_pkg::ARGS_W-1:0]  lim_args;
  logic                         room;
  logic                         accept;
  lprd_pkg::push_t              push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q  <= lprd_pkg::MAX_MESSAGE;
      max_args_q <= lprd_pkg::MAX_ARGS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lprd_pkg::CFG_MAX_MESSAGE: max_msg_q  <= cfg_data_i[lprd_pkg::MSG_W-1:0];
        lprd_pkg::CFG_MAX_ARGS:    max_args_q <= cfg_data_i[lprd_pkg::ARGS_W-1:0];
        default:                   max_msg_q  <= max_msg_q;
      endcase
    end
  end

  // limit in force is the smaller of register and build limit
  assign lim_msg  = (max_msg_q > lprd_pkg::MAX_MESSAGE) ? lprd_pkg::MAX_MESSAGE : max_msg_q;
  assign lim_args = (max_args_q > lprd_pkg::MAX_ARGS) ? lprd_pkg::MAX_ARGS : max_args_q;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  lprd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .lim_msg_i  (lim_msg),
    .lim_args_i (lim_args),
    .push_o     (push)
  );

  lprd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: bench/tb_length_prefixed_request_deframer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Request deframer testbench
// Feeds length-framed requests, broken ones and stray bytes through the
// deframer with random gaps and output stalls. An in-bench parser works out
// the results of every byte taken, and each result that leaves the block is
// checked field by field against them. Limits are changed between phases.
// ---------------------------------------------------------------------------
module tb_length_prefixed_request_deframer;

  typedef enum logic [1:0] {PH_LENGTH, PH_COUNT, PH_SIZE, PH_PAYLOAD} parse_phase_e;
  typedef enum int {
    FLAW_NONE, FLAW_LEN_UP, FLAW_LEN_DOWN, FLAW_COUNT_UP, FLAW_COUNT_DOWN,
    FLAW_SIZE_UP, FLAW_CUT, FLAW_NOISE
  } flaw_e;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  lprd_pkg::in_item_t            in_item_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  lprd_pkg::out_item_t           out_item_o;
  logic                          cfg_we_i    = 1'b0;
  logic                          cfg_index_i = lprd_pkg::CFG_MAX_MESSAGE;
  logic [lprd_pkg::CFG_W-1:0]    cfg_data_i  = '0;

  lprd_pkg::in_item_t    pending_bytes[$];
  lprd_pkg::out_item_t   expected_results[$];
  int          mismatch_count = 0;
  int          bytes_queued   = 0;
  bit          calm           = 1'b0;

  // limit registers as the block should hold them
  logic [lprd_pkg::MSG_W-1:0]  msg_limit_reg  = 13'd4096;
  logic [lprd_pkg::ARGS_W-1:0] args_limit_reg = 11'd1024;

  // parser state
  parse_phase_e                phase_q        = PH_LENGTH;
  logic [1:0]                  hdr_cnt        = '0;
  logic [lprd_pkg::HDR_W-1:0]  hdr_word       = '0;
  logic [lprd_pkg::MSG_W-1:0]  body_left      = '0;
  logic [lprd_pkg::ARGS_W-1:0] args_left      = '0;
  logic [lprd_pkg::MSG_W-1:0]  arg_bytes_left = '0;
  logic [lprd_pkg::IDX_W-1:0]  arg_idx        = '0;
  logic                        dead           = 1'b0;
  int                          step_results   = 0;

  length_prefixed_request_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- parser

  function automatic void clear_parse();
    phase_q        = PH_LENGTH;
    hdr_cnt        = '0;
    hdr_word       = '0;
    body_left      = '0;
    args_left      = '0;
    arg_bytes_left = '0;
    arg_idx        = '0;
    dead           = 1'b0;
  endfunction

  function automatic void add_result(logic [lprd_pkg::KIND_W-1:0] kind, logic [7:0] b,
                                     logic [lprd_pkg::IDX_W-1:0] idx, logic end_flag);
    lprd_pkg::out_item_t r;
    r.kind         = kind;
    r.payload_byte = b;
    r.arg_index    = idx;
    r.arg_end      = end_flag;
    r.last         = 1'b0;
    expected_results.insert(expected_results.size(), r);
    step_results++;
  endfunction

  function automatic void abort_request(logic [lprd_pkg::KIND_W-1:0] kind);
    add_result(kind, 8'd0, '0, 1'b0);
    clear_parse();
    dead = 1'b1;
  endfunction

  function automatic void close_request();
    add_result(lprd_pkg::KIND_DONE, 8'd0, '0, 1'b0);
    clear_parse();
  endfunction

  // true once the fourth little-endian byte is in
  function automatic logic gather_header(logic [7:0] b);
    hdr_word = hdr_word | ((lprd_pkg::HDR_W)'(b) << (8 * hdr_cnt));
    hdr_cnt  = hdr_cnt + 2'd1;
    return hdr_cnt == 2'd0;
  endfunction

  function automatic void use_body_byte();
    if (body_left != 0) body_left = body_left - 1'b1;
  endfunction

  function automatic void finish_argument();
    if (args_left != 0) args_left = args_left - 1'b1;
    arg_idx = arg_idx + 1'b1;
    if (args_left == 0) begin
      if (body_left == 0) close_request();
      else abort_request(lprd_pkg::KIND_BAD);
    end else if (body_left == 0) begin
      abort_request(lprd_pkg::KIND_BAD);
    end else begin
      phase_q = PH_SIZE;
    end
  endfunction

  function automatic void predict_deframe(lprd_pkg::in_item_t it);
    logic [lprd_pkg::HDR_W-1:0]  v;
    logic [lprd_pkg::MSG_W-1:0]  msg_lim;
    logic [lprd_pkg::ARGS_W-1:0] args_lim;
    step_results = 0;
    msg_lim  = (msg_limit_reg < lprd_pkg::MAX_MESSAGE) ? msg_limit_reg : lprd_pkg::MAX_MESSAGE;
    args_lim = (args_limit_reg < lprd_pkg::MAX_ARGS) ? args_limit_reg : lprd_pkg::MAX_ARGS;
    if (it.connection_start) begin
      clear_parse();
    end else if (!dead) begin
      case (phase_q)
        PH_LENGTH: begin
          if (gather_header(it.stream_byte)) begin
            v = hdr_word;
            hdr_word = '0;
            if (v > (lprd_pkg::HDR_W)'(msg_lim)) abort_request(lprd_pkg::KIND_LONG);
            else if (v < lprd_pkg::MIN_LENGTH) abort_request(lprd_pkg::KIND_BAD);
            else begin
              body_left = v[lprd_pkg::MSG_W-1:0];
              phase_q   = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          use_body_byte();
          if (gather_header(it.stream_byte)) begin
            v = hdr_word;
            hdr_word = '0;
            if (v > (lprd_pkg::HDR_W)'(args_lim)) abort_request(lprd_pkg::KIND_BAD);
            else if (v == 0) begin
              if (body_left == 0) close_request();
              else abort_request(lprd_pkg::KIND_BAD);
            end else if (body_left == 0) abort_request(lprd_pkg::KIND_BAD);
            else begin
              args_left = v[lprd_pkg::ARGS_W-1:0];
              arg_idx   = '0;
              phase_q   = PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          use_body_byte();
          if (!gather_header(it.stream_byte)) begin
            // body ran out inside the size header
            if (body_left == 0) abort_request(lprd_pkg::KIND_BAD);
          end else begin
            v = hdr_word;
            hdr_word = '0;
            if (v > (lprd_pkg::HDR_W)'(body_left)) abort_request(lprd_pkg::KIND_BAD);
            else if (v == 0) begin
              add_result(lprd_pkg::KIND_EMPTY, 8'd0, arg_idx, 1'b0);
              finish_argument();
            end else begin
              arg_bytes_left = v[lprd_pkg::MSG_W-1:0];
              phase_q        = PH_PAYLOAD;
            end
          end
        end
        default: begin
          use_body_byte();
          if (arg_bytes_left != 0) arg_bytes_left = arg_bytes_left - 1'b1;
          add_result(lprd_pkg::KIND_PAYLOAD, it.stream_byte, arg_idx, arg_bytes_left == 0);
          if (arg_bytes_left == 0) finish_argument();
        end
      endcase
    end
    if (step_results > 0) begin
      expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_deframe(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
          in_item_i  <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_item_i  <= lprd_pkg::in_item_t'($urandom);
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    lprd_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none actual %p", $time, out_item_o);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_item_o.kind));
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_item_o.payload_byte));
          check_field("arg_index", 16'(want.arg_index), 16'(out_item_o.arg_index));
          check_field("arg_end", 16'(want.arg_end), 16'(out_item_o.arg_end));
          check_field("last", 16'(want.last), 16'(out_item_o.last));
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 21);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_byte(logic [7:0] b);
    lprd_pkg::in_item_t it;
    it.stream_byte      = b;
    it.connection_start = 1'b0;
    pending_bytes.insert(pending_bytes.size(), it);
    bytes_queued++;
  endtask

  task automatic queue_start();
    lprd_pkg::in_item_t it;
    it.stream_byte      = 8'($urandom);
    it.connection_start = 1'b1;
    pending_bytes.insert(pending_bytes.size(), it);
    bytes_queued++;
  endtask

  task automatic queue_word(logic [31:0] w);
    for (int j = 0; j < 4; j++) queue_byte(w[8*j +: 8]);
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    // bytes that give no result may still be in the parser
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [lprd_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == lprd_pkg::CFG_MAX_MESSAGE) msg_limit_reg = data;
    else args_limit_reg = data[lprd_pkg::ARGS_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed requests with random content, some broken on purpose
  task automatic queue_random_request();
    int          sizes[$];
    logic [7:0]  bytes_q[$];
    int          nargs;
    int          body;
    int          cut;
    int          bad_arg;
    logic [31:0] w;
    flaw_e       flaw;
    logic [lprd_pkg::MSG_W-1:0]  msg_lim;
    logic [lprd_pkg::ARGS_W-1:0] args_lim;
    msg_lim  = (msg_limit_reg < lprd_pkg::MAX_MESSAGE) ? msg_limit_reg : lprd_pkg::MAX_MESSAGE;
    args_lim = (args_limit_reg < lprd_pkg::MAX_ARGS) ? args_limit_reg : lprd_pkg::MAX_ARGS;
    nargs = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 4);
    body  = 4;
    for (int i = 0; i < nargs; i++) begin
      sizes.insert(sizes.size(), ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 6));
      body += 4 + sizes[i];
    end
    flaw = ($urandom_range(99) < 75) ? FLAW_NONE
                                     : flaw_e'($urandom_range(FLAW_LEN_UP, FLAW_NOISE));
    if (flaw == FLAW_SIZE_UP && nargs == 0) flaw = FLAW_LEN_UP;
    bad_arg = (nargs > 0) ? $urandom_range(0, nargs - 1) : 0;

    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 8)) bytes_q.insert(bytes_q.size(), 8'($urandom));
    end else begin
      w = body;
      if (flaw == FLAW_LEN_UP) w = body + $urandom_range(1, 3);
      if (flaw == FLAW_LEN_DOWN) w = body - $urandom_range(1, 3);
      for (int j = 0; j < 4; j++) bytes_q.insert(bytes_q.size(), w[8*j +: 8]);
      w = nargs;
      if (flaw == FLAW_COUNT_UP) w = nargs + 1;
      if (flaw == FLAW_COUNT_DOWN) w = (nargs == 0) ? 1 : nargs - 1;
      for (int j = 0; j < 4; j++) bytes_q.insert(bytes_q.size(), w[8*j +: 8]);
      for (int i = 0; i < nargs; i++) begin
        w = sizes[i];
        if (flaw == FLAW_SIZE_UP && i == bad_arg) w = sizes[i] + $urandom_range(1, 3);
        for (int j = 0; j < 4; j++) bytes_q.insert(bytes_q.size(), w[8*j +: 8]);
        repeat (sizes[i]) bytes_q.insert(bytes_q.size(), 8'($urandom));
      end
    end
    cut = (flaw == FLAW_CUT) ? $urandom_range(1, bytes_q.size() - 1) : bytes_q.size();
    for (int i = 0; i < cut; i++) queue_byte(bytes_q[i]);
    // anything that may leave the parser dead or mid-request gets a fresh connection
    if (flaw != FLAW_NONE || body > msg_lim || nargs > args_lim || $urandom_range(99) < 5)
      queue_start();
  endtask

  task automatic run_random_phase(int n_items);
    int first;
    first = bytes_queued;
    while (bytes_queued - first < n_items) queue_random_request();
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest legal request: no arguments
    queue_word(32'd4);    queue_word(32'd0);
    // length too short to hold the count
    queue_word(32'd3);    queue_start();
    // length above the limit, then bytes on a dead connection
    queue_word(32'd4097); queue_start();
    queue_word(32'hFFFF_FFFF);
    queue_byte(8'h00);    queue_byte(8'hFF);
    queue_start();
    // no arguments but trailing body bytes
    queue_word(32'd5);    queue_word(32'd0);    queue_start();
    // count above the limit
    queue_word(32'd8);    queue_word(32'd1025); queue_start();
    // count at the limit, body runs out with arguments owed
    queue_word(32'd8);    queue_word(32'd1024); queue_word(32'd0); queue_start();
    queue_word(32'd4);    queue_word(32'd1);    queue_start();
    // single one-byte argument
    queue_word(32'd9);    queue_word(32'd1);    queue_word(32'd1); queue_byte(8'hFF);
    // two arguments
    queue_word(32'd15);   queue_word(32'd2);
    queue_word(32'd2);    queue_byte(8'h00);    queue_byte(8'hA5);
    queue_word(32'd1);    queue_byte(8'h5A);
    // body ends inside a size header
    queue_word(32'd6);    queue_word(32'd1);    queue_byte(8'h00); queue_byte(8'h00);
    queue_start();
    // size overruns the body
    queue_word(32'd8);    queue_word(32'd1);    queue_word(32'd1); queue_start();
    // last argument done with body left over
    queue_word(32'd10);   queue_word(32'd1);    queue_word(32'd1); queue_byte(8'h07);
    queue_start();
    // new connection in the middle of a payload
    queue_word(32'd9);    queue_word(32'd1);    queue_word(32'd2); queue_byte(8'h33);
    queue_start();
    // largest message accepted, dropped after two empty arguments
    queue_word(32'd4096); queue_word(32'd1023);
    queue_word(32'd0);    queue_word(32'd0);    queue_start();
    wait_idle();

    run_random_phase(110);

    write_limit(lprd_pkg::CFG_MAX_MESSAGE, 13'd4);
    write_limit(lprd_pkg::CFG_MAX_ARGS, 13'd0);
    run_random_phase(90);

    // all-ones writes: message limit is capped, argument limit is masked and capped
    write_limit(lprd_pkg::CFG_MAX_MESSAGE, 13'h1FFF);
    write_limit(lprd_pkg::CFG_MAX_ARGS, 13'h1FFF);
    calm = 1'b1;
    run_random_phase(110);
    calm = 1'b0;

    write_limit(lprd_pkg::CFG_MAX_MESSAGE, 13'd30);
    write_limit(lprd_pkg::CFG_MAX_ARGS, 13'd2);
    run_random_phase(100);

    write_limit(lprd_pkg::CFG_MAX_MESSAGE, 13'd4096);
    write_limit(lprd_pkg::CFG_MAX_ARGS, 13'd1024);
    run_random_phase(90);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
